@@ hdl/ftsc_pkg.sv @@
`timescale 1ns / 1ps
// ftsc_pkg: constants and types for the follow-target setpoint controller
// no dependencies; imported by follow_target_setpoint_ctrl

package ftsc_pkg;

  // register map, word index on the configuration port
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_ADDR_W = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_CENTER   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEADING_STEP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALTITUDE_GAIN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALTITUDE_MIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ALTITUDE_MAX   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_LENGTH   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_YAW_EVERY_STEP = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_IMAGE_CENTER  = 8'd65;
  localparam logic [7:0]  RST_DEAD_BAND     = 8'd10;
  localparam logic [15:0] RST_HEADING_STEP  = 16'd258;
  localparam logic [15:0] RST_ALTITUDE_GAIN = 16'd300;
  localparam logic [15:0] RST_ALTITUDE_MIN  = 16'd1000;
  localparam logic [15:0] RST_ALTITUDE_MAX  = 16'd3000;
  localparam logic [7:0]  RST_PHASE_LENGTH  = 8'd15;

  // setpoint constants, tenths of a degree
  localparam logic signed [7:0] ROLL_POS   = 8'sd75;
  localparam logic signed [7:0] ROLL_NEG   = -8'sd75;
  localparam logic signed [8:0] PITCH_NEAR = 9'sd130;
  localparam logic signed [8:0] PITCH_MID  = 9'sd50;
  localparam logic signed [8:0] PITCH_FAR  = -9'sd20;

  localparam logic [7:0] DIST_NEAR   = 8'd35;
  localparam logic [7:0] DIST_MID    = 8'd60;
  localparam logic [7:0] HEIGHT_HIGH = 8'd50;
  localparam logic [7:0] HEIGHT_LOW  = 8'd20;

  localparam logic [15:0] ALT_RESET = 16'd1000;

  typedef struct packed {
    logic [7:0]  image_center;
    logic [7:0]  dead_band;
    logic [15:0] heading_step;
    logic [15:0] altitude_gain;
    logic [15:0] altitude_min;
    logic [15:0] altitude_max;
    logic [7:0]  phase_length;
    logic        yaw_every_step;
  } cfg_t;

  typedef struct packed {
    logic [7:0] target_column;
    logic [7:0] target_height;
    logic [7:0] target_distance;
    logic       in_flight;
  } meas_t;

endpackage

@@ hdl/follow_target_setpoint_ctrl.sv @@
`timescale 1ns / 1ps
// follow_target_setpoint_ctrl: turns target measurements into roll, pitch,
// altitude and heading setpoints; depends on ftsc_pkg
//
// usage:
//   in_*  : one measurement item per valid/ready handshake
//   out_* : one setpoint item per measurement, same order, valid/ready
//   cfg_* : register port, register i at byte address 4*i, pready tied high;
//           write only while no item is in flight
// flow: an accepted item is captured in the input register and then moves
// on to the output register, from which its result is offered. throughput is
// one item per cycle while out_ready stays high, set by the single compute
// step between input register and output register, which also updates the
// phase, heading and altitude state.
// when out_ready is low the output register holds its item, the input
// register can still take one more item, and after that in_ready drops
// until the output side moves again.
// reset: registers return to their defaults, the phase counter and the
// heading accumulator clear, the altitude target goes to 1000 mm, and both
// pipeline stages empty.

module follow_target_setpoint_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_target_column,
  input  logic [7:0]                           in_target_height,
  input  logic [7:0]                           in_target_distance,
  input  logic                                 in_in_flight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [7:0]                    out_roll_ref,
  output logic signed [8:0]                    out_pitch_ref,
  output logic [15:0]                          out_altitude_ref,
  output logic signed [31:0]                   out_heading_ref,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ftsc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import ftsc_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  meas_t                meas_r;
  logic                 s1_vld_r;
  logic                 s1_adv;

  logic [7:0]           phase_count_r, phase_count_nxt;
  logic                 roll_phase_r, roll_phase_nxt;
  logic                 yaw_phase_r, yaw_phase_nxt;
  logic [31:0]          heading_acc_r, heading_acc_nxt;
  logic [15:0]          altitude_r, altitude_nxt;

  logic                 out_vld_r;
  logic signed [7:0]    roll_r, roll_nxt;
  logic signed [8:0]    pitch_r, pitch_nxt;

  logic [8:0]           count_inc;
  logic                 phase_end;
  logic [8:0]           diff_pos, diff_neg;
  logic                 go_pos, go_neg;
  logic signed [17:0]   alt_step, alt_hi;

  // configuration port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_center   <= RST_IMAGE_CENTER;
      cfg_r.dead_band      <= RST_DEAD_BAND;
      cfg_r.heading_step   <= RST_HEADING_STEP;
      cfg_r.altitude_gain  <= RST_ALTITUDE_GAIN;
      cfg_r.altitude_min   <= RST_ALTITUDE_MIN;
      cfg_r.altitude_max   <= RST_ALTITUDE_MAX;
      cfg_r.phase_length   <= RST_PHASE_LENGTH;
      cfg_r.yaw_every_step <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_CENTER:   cfg_r.image_center   <= cfg_pwdata[7:0];
        REG_DEAD_BAND:      cfg_r.dead_band      <= cfg_pwdata[7:0];
        REG_HEADING_STEP:   cfg_r.heading_step   <= cfg_pwdata[15:0];
        REG_ALTITUDE_GAIN:  cfg_r.altitude_gain  <= cfg_pwdata[15:0];
        REG_ALTITUDE_MIN:   cfg_r.altitude_min   <= cfg_pwdata[15:0];
        REG_ALTITUDE_MAX:   cfg_r.altitude_max   <= cfg_pwdata[15:0];
        REG_PHASE_LENGTH:   cfg_r.phase_length   <= cfg_pwdata[7:0];
        REG_YAW_EVERY_STEP: cfg_r.yaw_every_step <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_CENTER:   cfg_prdata = {24'd0, cfg_r.image_center};
      REG_DEAD_BAND:      cfg_prdata = {24'd0, cfg_r.dead_band};
      REG_HEADING_STEP:   cfg_prdata = {16'd0, cfg_r.heading_step};
      REG_ALTITUDE_GAIN:  cfg_prdata = {16'd0, cfg_r.altitude_gain};
      REG_ALTITUDE_MIN:   cfg_prdata = {16'd0, cfg_r.altitude_min};
      REG_ALTITUDE_MAX:   cfg_prdata = {16'd0, cfg_r.altitude_max};
      REG_PHASE_LENGTH:   cfg_prdata = {24'd0, cfg_r.phase_length};
      REG_YAW_EVERY_STEP: cfg_prdata = {31'd0, cfg_r.yaw_every_step};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // two-stage flow: input register, then output register
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r.target_column   <= in_target_column;
      meas_r.target_height   <= in_target_height;
      meas_r.target_distance <= in_target_distance;
      meas_r.in_flight       <= in_in_flight;
    end
  end

  // phase sequencing, counter increment is 9 bits so length 255 still ends
  always_comb begin
    count_inc = {1'b0, phase_count_r} + 9'd1;
    phase_end = count_inc > {1'b0, cfg_r.phase_length};
    if (phase_end) begin
      phase_count_nxt = 8'd0;
      roll_phase_nxt  = !roll_phase_r;
      yaw_phase_nxt   = roll_phase_r;
    end else begin
      phase_count_nxt = count_inc[7:0];
      roll_phase_nxt  = roll_phase_r;
      yaw_phase_nxt   = yaw_phase_r;
    end
  end

  // target direction outside the dead band
  always_comb begin
    diff_pos = {1'b0, meas_r.target_column} - {1'b0, cfg_r.image_center};
    diff_neg = {1'b0, cfg_r.image_center} - {1'b0, meas_r.target_column};
    go_pos   = (meas_r.target_column > cfg_r.image_center) &&
               (diff_pos > {1'b0, cfg_r.dead_band});
    go_neg   = (cfg_r.image_center > meas_r.target_column) &&
               (diff_neg > {1'b0, cfg_r.dead_band});
  end

  always_comb begin
    heading_acc_nxt = heading_acc_r;
    if (yaw_phase_nxt || cfg_r.yaw_every_step) begin
      if (go_pos) begin
        heading_acc_nxt = heading_acc_r + {16'd0, cfg_r.heading_step};
      end else if (go_neg) begin
        heading_acc_nxt = heading_acc_r - {16'd0, cfg_r.heading_step};
      end
    end
    roll_nxt = 8'sd0;
    if (roll_phase_nxt && go_pos) begin
      roll_nxt = ROLL_POS;
    end else if (roll_phase_nxt && go_neg) begin
      roll_nxt = ROLL_NEG;
    end
  end

  // altitude: signed 18-bit step, clamp to max then to min
  always_comb begin
    alt_step = $signed({2'b00, altitude_r});
    if (meas_r.in_flight) begin
      if (meas_r.target_height > HEIGHT_HIGH) begin
        alt_step = $signed({2'b00, altitude_r}) - $signed({2'b00, cfg_r.altitude_gain});
      end else if (meas_r.target_height < HEIGHT_LOW) begin
        alt_step = $signed({2'b00, altitude_r}) + $signed({2'b00, cfg_r.altitude_gain});
      end
    end
    alt_hi = alt_step;
    if (alt_step > $signed({2'b00, cfg_r.altitude_max})) begin
      alt_hi = $signed({2'b00, cfg_r.altitude_max});
    end
    if (alt_hi < $signed({2'b00, cfg_r.altitude_min})) begin
      altitude_nxt = cfg_r.altitude_min;
    end else begin
      altitude_nxt = alt_hi[15:0];
    end
  end

  always_comb begin
    if (meas_r.target_distance < DIST_NEAR) begin
      pitch_nxt = PITCH_NEAR;
    end else if (meas_r.target_distance < DIST_MID) begin
      pitch_nxt = PITCH_MID;
    end else begin
      pitch_nxt = PITCH_FAR;
    end
  end

  // state advances once per item as it moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_count_r <= 8'd0;
      roll_phase_r  <= 1'b0;
      yaw_phase_r   <= 1'b0;
      heading_acc_r <= 32'd0;
      altitude_r    <= ALT_RESET;
    end else if (s1_adv) begin
      phase_count_r <= phase_count_nxt;
      roll_phase_r  <= roll_phase_nxt;
      yaw_phase_r   <= yaw_phase_nxt;
      heading_acc_r <= heading_acc_nxt;
      altitude_r    <= altitude_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  // altitude and heading outputs are the state registers themselves
  assign out_valid        = out_vld_r;
  assign out_roll_ref     = roll_r;
  assign out_pitch_ref    = pitch_r;
  assign out_altitude_ref = altitude_r;
  assign out_heading_ref  = heading_acc_r;

endmodule
